/* rtl/vppt_pkg.sv */
`default_nettype none

package vppt_pkg;

  localparam int KindW  = 3;
  localparam int CountW = 8;
  localparam int InDataW  = 32;
  localparam int OutDataW = 8;

  localparam logic [KindW-1:0] KIND_TICK      = 3'd0;
  localparam logic [KindW-1:0] KIND_START     = 3'd1;
  localparam logic [KindW-1:0] KIND_CANCEL    = 3'd2;
  localparam logic [KindW-1:0] KIND_POWER_ON  = 3'd3;
  localparam logic [KindW-1:0] KIND_POWER_OFF = 3'd4;

  typedef struct packed {
    logic              battery_empty;
    logic [CountW-1:0] off_ticks;
    logic [CountW-1:0] on_ticks;
    logic              counted_mode;
    logic [CountW-1:0] repeat_count;
  } item_t;

  typedef struct packed {
    logic              running;
    logic              counted;
    logic              off_pending;
    logic [CountW-1:0] repeats_left;
    logic [CountW-1:0] on_reload;
    logic [CountW-1:0] on_left;
    logic [CountW-1:0] off_reload;
    logic [CountW-1:0] off_left;
    logic              drive;
  } state_t;

  typedef struct packed {
    logic pattern_active;
    logic motor_on;
  } result_t;

  localparam state_t STATE_CLEAR = '0;

endpackage

`default_nettype wire

/* rtl/vppt_core.sv */
`default_nettype none

module vppt_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic [vppt_pkg::KindW-1:0] kind,
  input  wire vppt_pkg::item_t            item,
  output      vppt_pkg::result_t          res_nxt
);
  import vppt_pkg::*;

  state_t            st_r;
  state_t            st_nxt;
  state_t            cancel_st;
  state_t            tick_st;
  logic [CountW-1:0] off_dec;
  logic [CountW-1:0] rep_dec;

  always_comb begin
    cancel_st             = STATE_CLEAR;
    cancel_st.off_pending = 1'b1;
  end

  assign off_dec = st_r.off_left - CountW'(1);
  assign rep_dec = st_r.repeats_left - CountW'(1);

  always_comb begin
    tick_st = st_r;
    if (!st_r.running) begin
      if (st_r.off_pending) begin
        tick_st.drive       = 1'b0;
        tick_st.off_pending = 1'b0;
      end
    end else if (st_r.on_left != '0) begin
      tick_st.on_left = st_r.on_left - CountW'(1);
      tick_st.drive   = 1'b1;
    end else begin
      tick_st.drive = 1'b0;
      if (st_r.off_left != '0) begin
        tick_st.off_left = off_dec;
        if (off_dec == '0) begin
          tick_st.off_left = st_r.off_reload;
          tick_st.on_left  = st_r.on_reload;
          if (st_r.counted && (st_r.repeats_left != '0)) begin
            tick_st.repeats_left = rep_dec;
            if (rep_dec == '0) begin
              tick_st = cancel_st;
            end
          end
        end
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (kind)
      KIND_TICK: begin
        st_nxt = tick_st;
      end
      KIND_START: begin
        if (item.battery_empty) begin
          st_nxt = cancel_st;
        end else begin
          st_nxt.running      = 1'b1;
          st_nxt.counted      = item.counted_mode;
          st_nxt.off_pending  = 1'b1;
          st_nxt.repeats_left = item.repeat_count;
          st_nxt.on_reload    = item.on_ticks;
          st_nxt.on_left      = item.on_ticks;
          st_nxt.off_reload   = item.off_ticks;
          st_nxt.off_left     = item.off_ticks;
        end
      end
      KIND_CANCEL: begin
        st_nxt = cancel_st;
      end
      KIND_POWER_ON: begin
        st_nxt       = STATE_CLEAR;
        st_nxt.drive = 1'b1;
      end
      KIND_POWER_OFF: begin
        st_nxt = STATE_CLEAR;
      end
      default: begin
        st_nxt = st_r;
      end
    endcase
  end

  assign res_nxt.motor_on       = st_nxt.drive;
  assign res_nxt.pattern_active = st_nxt.running;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_CLEAR;
    end else if (en) begin
      st_r <= st_nxt;
    end
  end

  a_run_pending: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.running |-> st_r.off_pending)
    else $error("running pattern without off_pending");

  a_idle_counts: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.running |-> (st_r.on_left == '0) && (st_r.off_left == '0))
    else $error("idle timer holds nonzero counts");

  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    en && (kind == KIND_TICK) && !st_r.running |=> !st_r.running && !st_r.off_pending)
    else $error("tick while idle started a pattern");

  a_power_on: assert property (@(posedge clk) disable iff (!rst_n)
    en && (kind == KIND_POWER_ON) |=> st_r.drive && !st_r.running)
    else $error("power on did not force the motor on");

endmodule

`default_nettype wire

/* rtl/vibration_pulse_pattern_timer.sv */
`default_nettype none

// Channel | Ports                      | Payload
// in      | in_tvalid/tready/tdata/tuser | tuser: kind; tdata: item fields
// out     | out_tvalid/tready/tdata    | tdata: motor_on, pattern_active
//
// One transfer in gives one transfer out; every item passes through the
// state update between the input register and the result register.
// out_tvalid is registered: the item waits in the input register and its
// result in the output register; one item per cycle sustained while
// out_tready is high.
// Synchronous active-low reset clears the pattern state (motor off, idle).
// A stalled result holds in the output register while the input register,
// if it is empty, still takes one more item.

module vibration_pulse_pattern_timer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output      logic                          in_tready,
  // [7:0] repeat_count, [8] counted_mode, [16:9] on_ticks,
  // [24:17] off_ticks, [25] battery_empty, [31:26] zero
  input  wire logic [vppt_pkg::InDataW-1:0]  in_tdata,
  // [2:0] kind
  input  wire logic [vppt_pkg::KindW-1:0]    in_tuser,
  output      logic                          out_tvalid,
  input  wire logic                          out_tready,
  // [0] motor_on, [1] pattern_active, [7:2] zero
  output      logic [vppt_pkg::OutDataW-1:0] out_tdata
);
  import vppt_pkg::*;

  logic              in_v_r;
  item_t             item_r;
  logic [KindW-1:0]  kind_r;
  logic              out_v_r;
  result_t           res_r;
  result_t           res_nxt;
  logic              advance;

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_t'(in_tdata[$bits(item_t)-1:0]);
      kind_r <= in_tuser;
    end
  end

  vppt_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance),
    .kind    (kind_r),
    .item    (item_r),
    .res_nxt (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {(OutDataW-2)'(0), res_r.pattern_active, res_r.motor_on};

endmodule

`default_nettype wire
